@@ rtl/pcs_pkg.sv @@
package pcs_pkg;

    // Field widths fixed by the register map and the channel payloads
    localparam int SETTING_W  = 13;
    localparam int PITCH_W    = 7;
    localparam int VEL_W      = 7;
    localparam int COUNT_W    = 4;
    localparam int SYNC_W     = 6;
    localparam int STAGE_W    = 3;
    localparam int CFG_REGS   = 8;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [SETTING_W-1:0] SETTING_RESET = 13'd188;
    localparam logic [VEL_W-1:0]     FULL_VELOCITY = 7'd127;

    // Bit positions inside a stage setting
    localparam int PITCH_LSB = 0;
    localparam int COUNT_LSB = 7;
    localparam int GATE_LSB  = 11;

    typedef enum logic [1:0] {
        GATE_REPEAT = 2'd0,
        GATE_ONCE   = 2'd1,
        GATE_HOLD   = 2'd2,
        GATE_REST   = 2'd3
    } t_gate;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SYNC,
        S_RST_SCAN,
        S_PLAY,
        S_EMIT_OFF,
        S_EMIT_ON,
        S_ADV,
        S_ADV_SCAN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic sync_init;
        logic sync_step;
        logic rst_init;
        logic scan_step;
        logic play_eval;
        logic emit_off;
        logic emit_on;
        logic adv_init;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ignore;
        logic do_sync;
        logic do_reset;
        logic sync_done;
        logic scan_done;
        logic emit_off;
        logic emit_on;
        logic out_free;
    } t_status;

endpackage

@@ rtl/pcs_if.sv @@
interface pcs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [pcs_pkg::VEL_W-1:0]     pulse_velocity;
    logic                          reset_flag;
    logic                          sync_flag;
    logic [pcs_pkg::SYNC_W-1:0]    sync_step;
    logic                          play_enabled;

    modport source (
        output valid, req_type, pulse_velocity, reset_flag, sync_flag, sync_step,
               play_enabled,
        input  ready
    );
    modport sink (
        input  valid, req_type, pulse_velocity, reset_flag, sync_flag, sync_step,
               play_enabled,
        output ready
    );
endinterface

interface pcs_out_if;
    logic                          valid;
    logic                          ready;
    logic [pcs_pkg::PITCH_W-1:0]   note_pitch;
    logic [pcs_pkg::VEL_W-1:0]     note_velocity;
    logic [pcs_pkg::STAGE_W-1:0]   stage_played;
    logic                          last_event;

    modport source (
        output valid, note_pitch, note_velocity, stage_played, last_event,
        input  ready
    );
    modport sink (
        input  valid, note_pitch, note_velocity, stage_played, last_event,
        output ready
    );
endinterface

@@ rtl/pcs_regs.sv @@
module pcs_regs #(
    parameter int STAGES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [pcs_pkg::SETTING_W-1:0]     o_setting [STAGES]
);

    localparam int IDX_W = pcs_pkg::APB_ADDR_W - 2;

    logic [pcs_pkg::SETTING_W-1:0] r_setting [STAGES];
    logic [pcs_pkg::SETTING_W-1:0] n_setting [STAGES];
    logic [IDX_W-1:0]              idx;
    logic                          wr;
    logic [pcs_pkg::SETTING_W-1:0] rd;

    assign idx    = paddr[pcs_pkg::APB_ADDR_W-1:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    // stages beyond the register map keep their reset value
    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            n_setting[i] = r_setting[i];
            if (wr && i < pcs_pkg::CFG_REGS && idx == IDX_W'(i)) begin
                n_setting[i] = pwdata[pcs_pkg::SETTING_W-1:0];
            end
        end
    end

    always_comb begin
        rd = '0;
        for (int i = 0; i < STAGES; i++) begin
            if (i < pcs_pkg::CFG_REGS && idx == IDX_W'(i)) begin
                rd = r_setting[i];
            end
        end
    end

    assign prdata = pcs_pkg::APB_DATA_W'(rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES; i++) begin
                r_setting[i] <= pcs_pkg::SETTING_RESET;
            end
        end else begin
            r_setting <= n_setting;
        end
    end

    assign o_setting = r_setting;

endmodule

@@ rtl/pcs_ctrl.sv @@
module pcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pcs_pkg::t_status i_status,
    output pcs_pkg::t_cmd    o_cmd
);

    pcs_pkg::t_state r_state;
    pcs_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcs_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pcs_pkg::S_DECIDE;
            end
            pcs_pkg::S_DECIDE: begin
                if (i_status.ignore)        n_state = pcs_pkg::S_IDLE;
                else if (i_status.do_sync)  n_state = pcs_pkg::S_SYNC;
                else if (i_status.do_reset) n_state = pcs_pkg::S_RST_SCAN;
                else                        n_state = pcs_pkg::S_PLAY;
            end
            pcs_pkg::S_SYNC: begin
                if (i_status.sync_done) n_state = pcs_pkg::S_PLAY;
            end
            pcs_pkg::S_RST_SCAN: begin
                if (i_status.scan_done) n_state = pcs_pkg::S_PLAY;
            end
            pcs_pkg::S_PLAY: begin
                n_state = pcs_pkg::S_EMIT_OFF;
            end
            pcs_pkg::S_EMIT_OFF: begin
                if (!i_status.emit_off || i_status.out_free) n_state = pcs_pkg::S_EMIT_ON;
            end
            pcs_pkg::S_EMIT_ON: begin
                if (!i_status.emit_on || i_status.out_free) n_state = pcs_pkg::S_ADV;
            end
            pcs_pkg::S_ADV: begin
                n_state = pcs_pkg::S_ADV_SCAN;
            end
            pcs_pkg::S_ADV_SCAN: begin
                if (i_status.scan_done) n_state = pcs_pkg::S_IDLE;
            end
            default: n_state = pcs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pcs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pcs_pkg::S_DECIDE: begin
                o_cmd.sync_init = !i_status.ignore && i_status.do_sync;
                o_cmd.rst_init  = !i_status.ignore && !i_status.do_sync && i_status.do_reset;
            end
            pcs_pkg::S_SYNC:     o_cmd.sync_step = 1'b1;
            pcs_pkg::S_RST_SCAN: o_cmd.scan_step = 1'b1;
            pcs_pkg::S_PLAY:     o_cmd.play_eval = 1'b1;
            pcs_pkg::S_EMIT_OFF: o_cmd.emit_off  = i_status.emit_off && i_status.out_free;
            pcs_pkg::S_EMIT_ON:  o_cmd.emit_on   = i_status.emit_on && i_status.out_free;
            pcs_pkg::S_ADV:      o_cmd.adv_init  = 1'b1;
            pcs_pkg::S_ADV_SCAN: o_cmd.scan_step = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // an accepted word always starts the decision step
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == pcs_pkg::S_DECIDE)
        else $error("accepted word did not reach decide");

    // no new word is taken while a pulse is still being worked
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_cmd.emit_off || o_cmd.emit_on || o_cmd.scan_step))
        else $error("ready raised mid-pulse");

endmodule

@@ rtl/pcs_dp.sv @@
module pcs_dp #(
    parameter int STAGES     = 8,
    parameter int MAX_PULSES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcs_pkg::t_cmd                  i_cmd,
    output pcs_pkg::t_status               o_status,
    input  logic [pcs_pkg::SETTING_W-1:0]  i_setting [STAGES],
    input  logic                           i_req_type,
    input  logic [pcs_pkg::VEL_W-1:0]      i_pulse_velocity,
    input  logic                           i_reset_flag,
    input  logic                           i_sync_flag,
    input  logic [pcs_pkg::SYNC_W-1:0]     i_sync_step,
    input  logic                           i_play_enabled,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pcs_pkg::PITCH_W-1:0]    o_note_pitch,
    output logic [pcs_pkg::VEL_W-1:0]      o_note_velocity,
    output logic [pcs_pkg::STAGE_W-1:0]    o_stage_played,
    output logic                           o_last_event
);

    localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int PW = $clog2(MAX_PULSES + 1);
    localparam int IW = $clog2(STAGES + 1);
    localparam int RW = pcs_pkg::SYNC_W;

    function automatic logic [PW-1:0] sat_count(input logic [pcs_pkg::SETTING_W-1:0] s);
        logic [pcs_pkg::COUNT_W-1:0] raw;
        raw = s[pcs_pkg::COUNT_LSB +: pcs_pkg::COUNT_W];
        return (raw > pcs_pkg::COUNT_W'(MAX_PULSES)) ? PW'(MAX_PULSES) : PW'(raw);
    endfunction

    // position and held note
    logic [SW-1:0]               r_stage,      n_stage;
    logic [PW-1:0]               r_pulse,      n_pulse;
    logic [IW-1:0]               r_iter,       n_iter;
    logic [RW-1:0]               r_remain,     n_remain;
    logic [pcs_pkg::PITCH_W-1:0] r_held_pitch, n_held_pitch;
    logic                        r_held_valid, n_held_valid;
    logic                        r_ext_seen,   n_ext_seen;
    // latched word
    logic                        r_ignore,     n_ignore;
    logic                        r_do_reset,   n_do_reset;
    logic                        r_do_sync,    n_do_sync;
    logic                        r_play_en,    n_play_en;
    logic [pcs_pkg::VEL_W-1:0]   r_vel,        n_vel;
    logic                        r_emit_off,   n_emit_off;
    logic                        r_emit_on,    n_emit_on;
    // output stage
    logic                        r_out_valid,  n_out_valid;
    logic [pcs_pkg::PITCH_W-1:0] r_out_pitch,  n_out_pitch;
    logic [pcs_pkg::VEL_W-1:0]   r_out_vel,    n_out_vel;
    logic [pcs_pkg::STAGE_W-1:0] r_out_stage,  n_out_stage;
    logic                        r_out_last,   n_out_last;

    logic [pcs_pkg::SETTING_W-1:0] cur;
    logic [pcs_pkg::PITCH_W-1:0]   cur_pitch;
    pcs_pkg::t_gate                cur_gate;
    logic [PW-1:0]                 cur_cnt;
    logic [PW-1:0]                 cnt0;
    logic [SW-1:0]                 stage_next;
    logic                          stage_last;
    logic [SW+2:0]                 stage_ext;
    logic [pcs_pkg::STAGE_W-1:0]   stage_out;
    logic                          scan_done;
    logic                          sync_hit;
    logic                          out_free;
    logic                          stop;
    logic                          play;

    assign cur        = i_setting[r_stage];
    assign cur_pitch  = cur[pcs_pkg::PITCH_LSB +: pcs_pkg::PITCH_W];
    assign cur_gate   = pcs_pkg::t_gate'(cur[pcs_pkg::GATE_LSB +: 2]);
    assign cur_cnt    = sat_count(cur);
    assign cnt0       = sat_count(i_setting[0]);
    assign stage_last = (r_stage == SW'(STAGES - 1));
    assign stage_next = stage_last ? '0 : r_stage + SW'(1);
    assign stage_ext  = (SW + 3)'(r_stage);
    assign stage_out  = stage_ext[pcs_pkg::STAGE_W-1:0];
    assign scan_done  = !((r_pulse >= cur_cnt) && (r_iter < IW'(STAGES)));
    assign sync_hit   = (r_remain < RW'(cur_cnt));
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        stop = 1'b0;
        play = 1'b0;
        if (r_play_en) begin
            stop = (r_pulse == '0) || (cur_gate == pcs_pkg::GATE_REPEAT) ||
                   (cur_gate == pcs_pkg::GATE_ONCE);
            play = (((r_pulse == '0) && ((cur_gate == pcs_pkg::GATE_ONCE) ||
                                         (cur_gate == pcs_pkg::GATE_HOLD))) ||
                    (cur_gate == pcs_pkg::GATE_REPEAT)) && (cur_cnt != '0);
        end else begin
            stop = 1'b1;
        end
    end

    always_comb begin
        n_stage      = r_stage;
        n_pulse      = r_pulse;
        n_iter       = r_iter;
        n_remain     = r_remain;
        n_held_pitch = r_held_pitch;
        n_held_valid = r_held_valid;
        n_ext_seen   = r_ext_seen;
        n_ignore     = r_ignore;
        n_do_reset   = r_do_reset;
        n_do_sync    = r_do_sync;
        n_play_en    = r_play_en;
        n_vel        = r_vel;
        n_emit_off   = r_emit_off;
        n_emit_on    = r_emit_on;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_pitch  = r_out_pitch;
        n_out_vel    = r_out_vel;
        n_out_stage  = r_out_stage;
        n_out_last   = r_out_last;

        if (i_cmd.load) begin
            // ticks drop their flags and play at full velocity
            n_ignore   = !i_req_type && r_ext_seen;
            n_ext_seen = r_ext_seen | i_req_type;
            n_vel      = i_req_type ? i_pulse_velocity : pcs_pkg::FULL_VELOCITY;
            n_do_reset = i_req_type & i_reset_flag;
            n_do_sync  = i_req_type & i_sync_flag;
            n_remain   = i_sync_step;
            n_play_en  = i_play_enabled;
        end

        if (i_cmd.sync_init) begin
            n_stage = '0;
        end

        // walk stages, taking off each pulse count until the step lands or wraps to 0
        if (i_cmd.sync_step) begin
            if (sync_hit) begin
                n_pulse = PW'(r_remain);
            end else if (stage_last) begin
                n_stage = '0;
                n_pulse = '0;
            end else begin
                n_remain = r_remain - RW'(cur_cnt);
                n_stage  = stage_next;
            end
        end

        // empty first stage counts as a pulse already used
        if (i_cmd.rst_init) begin
            n_stage = '0;
            n_pulse = (cnt0 == '0) ? PW'(1) : '0;
            n_iter  = '0;
        end

        if (i_cmd.adv_init) begin
            n_pulse = r_pulse + PW'(1);
            n_iter  = '0;
        end

        if (i_cmd.scan_step && !scan_done) begin
            n_pulse = '0;
            n_stage = stage_next;
            n_iter  = r_iter + IW'(1);
        end

        if (i_cmd.play_eval) begin
            n_emit_off = stop && r_held_valid;
            n_emit_on  = play;
        end

        if (i_cmd.emit_off) begin
            n_out_valid  = 1'b1;
            n_out_pitch  = r_held_pitch;
            n_out_vel    = '0;
            n_out_stage  = stage_out;
            n_out_last   = !r_emit_on;
            n_held_valid = 1'b0;
        end

        if (i_cmd.emit_on) begin
            n_out_valid  = 1'b1;
            n_out_pitch  = cur_pitch;
            n_out_vel    = r_vel;
            n_out_stage  = stage_out;
            n_out_last   = 1'b1;
            n_held_pitch = cur_pitch;
            n_held_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= '0;
            r_pulse      <= '0;
            r_iter       <= '0;
            r_held_pitch <= '0;
            r_held_valid <= 1'b0;
            r_ext_seen   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_stage      <= n_stage;
            r_pulse      <= n_pulse;
            r_iter       <= n_iter;
            r_held_pitch <= n_held_pitch;
            r_held_valid <= n_held_valid;
            r_ext_seen   <= n_ext_seen;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain    <= n_remain;
        r_ignore    <= n_ignore;
        r_do_reset  <= n_do_reset;
        r_do_sync   <= n_do_sync;
        r_play_en   <= n_play_en;
        r_vel       <= n_vel;
        r_emit_off  <= n_emit_off;
        r_emit_on   <= n_emit_on;
        r_out_pitch <= n_out_pitch;
        r_out_vel   <= n_out_vel;
        r_out_stage <= n_out_stage;
        r_out_last  <= n_out_last;
    end

    assign o_status.ignore    = r_ignore;
    assign o_status.do_sync   = r_do_sync;
    assign o_status.do_reset  = r_do_reset;
    assign o_status.sync_done = sync_hit || stage_last;
    assign o_status.scan_done = scan_done;
    assign o_status.emit_off  = r_emit_off;
    assign o_status.emit_on   = r_emit_on;
    assign o_status.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_note_pitch    = r_out_pitch;
    assign o_note_velocity = r_out_vel;
    assign o_stage_played  = r_out_stage;
    assign o_last_event    = r_out_last;

    // a word is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_off || i_cmd.emit_on) |-> out_free)
        else $error("output word overwritten");

    // the lap search is bounded to one full lap
    a_lap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= IW'(STAGES))
        else $error("stage search ran past one lap");

    // a started note is held afterwards
    a_on_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_on |=> r_held_valid && r_out_valid && r_out_last)
        else $error("note-on not recorded as held");

endmodule

@@ rtl/pulse_count_stage_sequencer_core.sv @@
// Channel   Dir   Handshake        Word
// i_in      in    valid / ready    req_type, pulse_velocity, reset_flag, sync_flag,
//                                  sync_step, play_enabled
// o_out     out   valid / ready    note_pitch, note_velocity, stage_played, last_event
// APB       in    psel / penable   stage settings 0..7 at paddr 4*i, pready tied high
//
// One pulse at a time: accept, decide, optional sync walk or reset search, evaluate,
// two emit slots, advance and lap search. An ignored tick goes from decide straight
// back to idle. The stage search loops set the worst case; output stalls add to it.
// Reset is synchronous, active low; settings return to pitch 60, one pulse, repeat.
// A stalled o_out holds the controller in its emit slot; i_in stays low-ready meanwhile.
module pulse_count_stage_sequencer_core #(
    parameter int STAGES     = 8,
    parameter int MAX_PULSES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pcs_in_if.sink                            i_in,
    pcs_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [pcs_pkg::SETTING_W-1:0] setting [STAGES];
    pcs_pkg::t_cmd                 cmd;
    pcs_pkg::t_status              status;
    logic                          in_ready;

    // stage settings register file
    pcs_regs #(
        .STAGES (STAGES)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_setting (setting)
    );

    // sequencing of one pulse
    pcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // position, held note and the output register
    pcs_dp #(
        .STAGES     (STAGES),
        .MAX_PULSES (MAX_PULSES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_setting        (setting),
        .i_req_type       (i_in.req_type),
        .i_pulse_velocity (i_in.pulse_velocity),
        .i_reset_flag     (i_in.reset_flag),
        .i_sync_flag      (i_in.sync_flag),
        .i_sync_step      (i_in.sync_step),
        .i_play_enabled   (i_in.play_enabled),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_note_pitch     (o_out.note_pitch),
        .o_note_velocity  (o_out.note_velocity),
        .o_stage_played   (o_out.stage_played),
        .o_last_event     (o_out.last_event)
    );

endmodule
